### src/hsvrgb_pkg.sv
// Shared constants, types and helpers for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// Default channel width; saturation, value and the three colours share it.
	localparam int unsigned CHANNEL_BITS_DEF = 8;

	// Hue is degrees times 64 in a fixed 15-bit field.
	localparam int unsigned HUE_W       = 15;
	localparam int unsigned HUE_FULL    = 23040;
	localparam int unsigned SECTOR_SPAN = 3840;
	localparam int unsigned REM_W       = 12;
	localparam int unsigned SECT_W      = 3;

	// SECTOR_SPAN = SPAN_ODD << SPAN_SHIFT
	localparam int unsigned SPAN_SHIFT = 8;
	localparam int unsigned SPAN_ODD   = SECTOR_SPAN >> SPAN_SHIFT;

	// Register stages from input transfer to output register.
	localparam int unsigned NUM_STAGES = 6;

	// Hue sectors of 60 degrees each.
	localparam logic [SECT_W-1:0] SECT_RED     = 3'd0;
	localparam logic [SECT_W-1:0] SECT_YELLOW  = 3'd1;
	localparam logic [SECT_W-1:0] SECT_GREEN   = 3'd2;
	localparam logic [SECT_W-1:0] SECT_CYAN    = 3'd3;
	localparam logic [SECT_W-1:0] SECT_BLUE    = 3'd4;
	localparam logic [SECT_W-1:0] SECT_MAGENTA = 3'd5;

	// Load strobes for the pipeline registers, one per stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Hue at which a sector starts.
	function automatic logic [HUE_W-1:0] sect_base(input logic [SECT_W-1:0] sect);
		logic [HUE_W-1:0] base;
		case (sect)
			SECT_RED:     base = HUE_W'(0);
			SECT_YELLOW:  base = HUE_W'(SECTOR_SPAN);
			SECT_GREEN:   base = HUE_W'(2 * SECTOR_SPAN);
			SECT_CYAN:    base = HUE_W'(3 * SECTOR_SPAN);
			SECT_BLUE:    base = HUE_W'(4 * SECTOR_SPAN);
			SECT_MAGENTA: base = HUE_W'(5 * SECTOR_SPAN);
			default:      base = HUE_W'(0);
		endcase
		return base;
	endfunction

endpackage

### src/hsv_if.sv
// Valid/ready channel carrying one HSV pixel.
`timescale 1ns / 1ps

interface hsv_if import hsvrgb_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [HUE_W-1:0]        hue;
	logic [CHANNEL_BITS-1:0] saturation;
	logic [CHANNEL_BITS-1:0] value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

### src/rgb_if.sv
// Valid/ready channel carrying one RGB pixel.
`timescale 1ns / 1ps

interface rgb_if import hsvrgb_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] red;
	logic [CHANNEL_BITS-1:0] green;
	logic [CHANNEL_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### src/hsvrgb_ctrl.sv
// Valid bits and per-stage load strobes for the converter pipeline.
`timescale 1ns / 1ps

module hsvrgb_ctrl import hsvrgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output stage_en_t en
);

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] up;
	logic [NUM_STAGES:1] rdy;
	logic [NUM_STAGES:1] load;

	// A stage takes new data when it is empty or its contents move on.
	always_comb begin
		rdy[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
		up[1] = in_valid;
		for (int i = 2; i <= NUM_STAGES; i++) begin
			up[i] = vld_q[i-1];
		end
		load = rdy & up;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= up[i];
				end
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[NUM_STAGES];

	assign en.s1 = load[1];
	assign en.s2 = load[2];
	assign en.s3 = load[3];
	assign en.s4 = load[4];
	assign en.s5 = load[5];
	assign en.s6 = load[6];

endmodule

### src/hsvrgb_sector.sv
// First stage: hue wrap, sector split and remainder.
`timescale 1ns / 1ps

module hsvrgb_sector import hsvrgb_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [HUE_W-1:0]        hue,
	input  logic [CHANNEL_BITS-1:0] saturation,
	input  logic [CHANNEL_BITS-1:0] value,
	output logic [SECT_W-1:0]       sect_s1,
	output logic [REM_W-1:0]        rem_s1,
	output logic                    grey_s1,
	output logic [CHANNEL_BITS-1:0] sat_s1,
	output logic [CHANNEL_BITS-1:0] val_s1
);

	logic [HUE_W-1:0]  hue_wrap;
	logic [SECT_W-1:0] sect;
	logic [HUE_W-1:0]  rem_full;

	always_comb begin
		// one subtraction covers every 15-bit hue
		hue_wrap = (hue >= HUE_W'(HUE_FULL)) ? hue - HUE_W'(HUE_FULL) : hue;
		sect = SECT_RED;
		for (int i = 1; i < 6; i++) begin
			if (hue_wrap >= HUE_W'(i * SECTOR_SPAN)) begin
				sect = SECT_W'(i);
			end
		end
		rem_full = hue_wrap - sect_base(sect);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sect_s1 <= sect;
			rem_s1  <= rem_full[REM_W-1:0];
			grey_s1 <= (saturation == '0);
			sat_s1  <= saturation;
			val_s1  <= value;
		end
	end

endmodule

### src/hsvrgb_lane.sv
// One channel term: v*(M*3840 - s*k) / (M*3840), truncated, over four stages.
`timescale 1ns / 1ps

module hsvrgb_lane import hsvrgb_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  stage_en_t               en,
	input  logic [CHANNEL_BITS-1:0] sat_s1,
	input  logic [REM_W-1:0]        k_s1,
	input  logic [CHANNEL_BITS-1:0] val_s2,
	output logic [CHANNEL_BITS-1:0] quot
);

	localparam int unsigned N   = CHANNEL_BITS;
	localparam int unsigned PW  = N + REM_W;     // s*k and the numerator
	localparam int unsigned XW  = 2 * N + REM_W; // v times numerator
	localparam int unsigned YW  = XW - SPAN_SHIFT;
	localparam int unsigned DW  = N + 4;         // 15*M
	localparam logic [N-1:0]  M    = '1;
	localparam logic [PW-1:0] DEN  = PW'(M) * PW'(SECTOR_SPAN);
	localparam logic [DW-1:0] DIV  = DW'(M) * DW'(SPAN_ODD);
	localparam logic [63:0]   RECIP_FULL = (64'd1 << YW) / 64'(DIV);
	localparam int unsigned   RW   = $clog2(RECIP_FULL + 64'd1);
	localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

	logic [PW-1:0]    prod_s2;
	logic [XW-1:0]    x_s3;
	logic [YW-1:0]    y_s4;
	logic [N-1:0]     qhat_s4;
	logic [YW-1:0]    y_s5;
	logic [YW-1:0]    pd_s5;
	logic [N-1:0]     qhat_s5;
	logic [PW-1:0]    num;
	logic [YW+RW-1:0] yr;
	logic [YW-1:0]    resid;

	// Stage 2: saturation times hue weight.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PW'(sat_s1) * PW'(k_s1);
		end
	end

	// Stage 3: numerator, then times value.
	assign num = DEN - prod_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			x_s3 <= XW'(val_s2) * XW'(num);
		end
	end

	// Stage 4: drop the power-of-two part of the divisor, estimate the
	// quotient by 15*M with a reciprocal; the estimate is low by at most one.
	assign yr = (YW+RW)'(x_s3[XW-1:SPAN_SHIFT]) * (YW+RW)'(RECIP);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			y_s4    <= x_s3[XW-1:SPAN_SHIFT];
			qhat_s4 <= yr[YW +: N];
		end
	end

	// Stage 5: multiply the estimate back.
	always_ff @(posedge clk) begin
		if (en.s5) begin
			y_s5    <= y_s4;
			qhat_s5 <= qhat_s4;
			pd_s5   <= YW'(qhat_s4) * YW'(DIV);
		end
	end

	// Correct a low estimate.
	assign resid = y_s5 - pd_s5;
	assign quot  = (resid >= YW'(DIV)) ? qhat_s5 + N'(1) : qhat_s5;

endmodule

### src/hsv_to_rgb_convert.sv
// Top level of the HSV to RGB pixel converter.
`timescale 1ns / 1ps

// HSV to RGB converter. Takes hue (degrees times 64, wrapped once modulo 360
// degrees), saturation and value as CHANNEL_BITS-bit fractions where all ones
// means 1.0, and returns red, green and blue in the same format, truncated.
// One pixel enters per clock while the first stage is not held by an output
// stall. A result passes through six register stages from its input transfer
// to the output register (sector split, weight multiply, value multiply,
// reciprocal estimate, multiply-back, output select). The throughput is one
// pixel per cycle whenever the output side is ready. A stall on the output
// holds each occupied stage that has no empty stage after it, while stages
// before an empty stage keep moving into it, so no pixel is lost or repeated.
// Zero saturation gives grey. There is no configuration and no state between
// pixels.

module hsv_to_rgb_convert import hsvrgb_pkg::*; #(
	parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	hsv_if.sink hsv,
	rgb_if.source rgb
);

	localparam int unsigned N = CHANNEL_BITS;

	stage_en_t         en;

	logic [SECT_W-1:0] sect_s1, sect_s2, sect_s3, sect_s4, sect_s5;
	logic              grey_s1, grey_s2, grey_s3, grey_s4, grey_s5;
	logic [N-1:0]      val_s1, val_s2, val_s3, val_s4, val_s5;
	logic [N-1:0]      sat_s1;
	logic [REM_W-1:0]  rem_s1;
	logic [REM_W-1:0]  kp, kq, kt;
	logic [N-1:0]      p, q, t;
	logic [N-1:0]      red_s6, green_s6, blue_s6;

	// handshake and valid bits
	hsvrgb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hsv.valid),
		.in_ready  (hsv.ready),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.en        (en)
	);

	// stage 1: wrap hue, split into sector and remainder
	hsvrgb_sector #(.CHANNEL_BITS(N)) u_sector (
		.clk        (clk),
		.en         (en.s1),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.value      (hsv.value),
		.sect_s1    (sect_s1),
		.rem_s1     (rem_s1),
		.grey_s1    (grey_s1),
		.sat_s1     (sat_s1),
		.val_s1     (val_s1)
	);

	// Weights per term: p uses the full span, q the remainder, t its complement.
	assign kp = REM_W'(SECTOR_SPAN);
	assign kq = rem_s1;
	assign kt = REM_W'(SECTOR_SPAN) - rem_s1;

	hsvrgb_lane #(.CHANNEL_BITS(N)) u_lane_p (
		.clk    (clk),
		.en     (en),
		.sat_s1 (sat_s1),
		.k_s1   (kp),
		.val_s2 (val_s2),
		.quot   (p)
	);

	hsvrgb_lane #(.CHANNEL_BITS(N)) u_lane_q (
		.clk    (clk),
		.en     (en),
		.sat_s1 (sat_s1),
		.k_s1   (kq),
		.val_s2 (val_s2),
		.quot   (q)
	);

	hsvrgb_lane #(.CHANNEL_BITS(N)) u_lane_t (
		.clk    (clk),
		.en     (en),
		.sat_s1 (sat_s1),
		.k_s1   (kt),
		.val_s2 (val_s2),
		.quot   (t)
	);

	// Carry sector, grey flag and value alongside the lanes.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			sect_s2 <= sect_s1;
			grey_s2 <= grey_s1;
			val_s2  <= val_s1;
		end
		if (en.s3) begin
			sect_s3 <= sect_s2;
			grey_s3 <= grey_s2;
			val_s3  <= val_s2;
		end
		if (en.s4) begin
			sect_s4 <= sect_s3;
			grey_s4 <= grey_s3;
			val_s4  <= val_s3;
		end
		if (en.s5) begin
			sect_s5 <= sect_s4;
			grey_s5 <= grey_s4;
			val_s5  <= val_s4;
		end
	end

	// Stage 6: pick channels by sector into the output register; grey
	// overrides. The register holds while the output transfer is stalled.
	always_ff @(posedge clk) begin
		if (en.s6) begin
			if (grey_s5) begin
				red_s6   <= val_s5;
				green_s6 <= val_s5;
				blue_s6  <= val_s5;
			end else begin
				case (sect_s5)
					SECT_RED: begin
						red_s6 <= val_s5; green_s6 <= t;      blue_s6 <= p;
					end
					SECT_YELLOW: begin
						red_s6 <= q;      green_s6 <= val_s5; blue_s6 <= p;
					end
					SECT_GREEN: begin
						red_s6 <= p;      green_s6 <= val_s5; blue_s6 <= t;
					end
					SECT_CYAN: begin
						red_s6 <= p;      green_s6 <= q;      blue_s6 <= val_s5;
					end
					SECT_BLUE: begin
						red_s6 <= t;      green_s6 <= p;      blue_s6 <= val_s5;
					end
					default: begin
						red_s6 <= val_s5; green_s6 <= p;      blue_s6 <= q;
					end
				endcase
			end
		end
	end

	assign rgb.red   = red_s6;
	assign rgb.green = green_s6;
	assign rgb.blue  = blue_s6;

endmodule
